>>> src/bpo_pkg.sv
`default_nettype none

package bpo_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgDebounce = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHoldOff  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdleOff  = 2'd2;

  localparam logic [15:0] DebounceRst = 16'd50;
  localparam logic [15:0] HoldOffRst  = 16'd3000;
  localparam logic [31:0] IdleOffRst  = 32'd600000;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] hold_off_ms;
    logic [31:0] idle_off_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        button_level;
    logic        busy_req;
    logic        usb_present;
    logic        activity;
  } item_t;

  typedef struct packed {
    logic        power_latch;
    logic        power_off_event;
    logic        led_red_set;
    logic        led_clear;
  } result_t;

  typedef struct packed {
    logic        stable_level;
    logic        last_raw_level;
    logic [31:0] change_time;
    logic [31:0] press_start;
    logic        hold_flagged;
    logic [31:0] last_activity_ms;
    logic        is_off;
  } state_t;

endpackage

`default_nettype wire

>>> src/bpo_core.sv
`default_nettype none

// One service pass: next state and result from the current state and one item.
module bpo_core (
  input  bpo_pkg::cfg_t    cfg_i,
  input  bpo_pkg::state_t  state_i,
  input  bpo_pkg::item_t   item_i,
  output bpo_pkg::state_t  state_o,
  output bpo_pkg::result_t result_o
);

  logic [31:0] deb_dt;
  logic [31:0] held;
  logic [31:0] hold_dt;
  logic [31:0] idle_dt;
  logic [31:0] change_time;
  logic [31:0] act_time;
  logic        accept;
  logic        release_off;

  always_comb begin
    state_o  = state_i;
    result_o = '{power_latch: 1'b1, power_off_event: 1'b0,
                 led_red_set: 1'b0, led_clear: 1'b0};
    deb_dt      = '0;
    held        = '0;
    hold_dt     = '0;
    idle_dt     = '0;
    change_time = '0;
    act_time    = '0;
    accept      = 1'b0;
    release_off = 1'b0;

    if (state_i.is_off) begin
      result_o = '0;
    end else begin
      act_time = item_i.activity ? item_i.now_ms : state_i.last_activity_ms;
      state_o.last_activity_ms = act_time;

      // debounce
      change_time = (item_i.button_level != state_i.last_raw_level) ?
                    item_i.now_ms : state_i.change_time;
      state_o.change_time    = change_time;
      state_o.last_raw_level = item_i.button_level;
      deb_dt = item_i.now_ms - change_time;
      accept = (deb_dt >= {16'd0, cfg_i.debounce_ms}) &&
               (item_i.button_level != state_i.stable_level);

      if (accept) begin
        state_o.stable_level = item_i.button_level;
        if (item_i.button_level) begin
          state_o.press_start      = item_i.now_ms;
          state_o.hold_flagged     = 1'b0;
          state_o.last_activity_ms = item_i.now_ms;
        end else begin
          held = item_i.now_ms - state_i.press_start;
          state_o.press_start = '0;
          result_o.led_clear  = state_i.hold_flagged;
          release_off = (state_i.press_start != '0) &&
                        (held >= {16'd0, cfg_i.hold_off_ms});
        end
      end

      if (release_off) begin
        state_o.is_off           = 1'b1;
        result_o.power_latch     = 1'b0;
        result_o.power_off_event = 1'b1;
      end else begin
        // hold indication
        hold_dt = item_i.now_ms - state_o.press_start;
        if (state_o.stable_level && (state_o.press_start != '0) &&
            !state_o.hold_flagged && (hold_dt >= {16'd0, cfg_i.hold_off_ms})) begin
          state_o.hold_flagged = 1'b1;
          result_o.led_red_set = 1'b1;
        end

        // inactivity timer
        idle_dt = item_i.now_ms - state_o.last_activity_ms;
        if (item_i.busy_req) begin
          state_o.last_activity_ms = item_i.now_ms;
        end else if (idle_dt >= cfg_i.idle_off_ms) begin
          if (item_i.usb_present) begin
            state_o.last_activity_ms = item_i.now_ms;
          end else begin
            state_o.is_off           = 1'b1;
            result_o.power_latch     = 1'b0;
            result_o.power_off_event = 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> src/button_power_off_and_idle_timer.sv
// Path: input register, then the core, then the result register; a pass is one combinational
// step on the state, and a stall at the result register holds the item in the input register.
// Throughput: one service pass per cycle unless the result register is stalled.
// The input register advances whenever the result register is empty or being taken.
// Reset (rst_ni low, asynchronous): state cleared, registers to defaults (debounce 50,
// hold 3000, idle 600000); pipeline empty. The result register itself is not reset.
`default_nettype none

module button_power_off_and_idle_timer (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // item channel
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  [31:0]                       now_ms_i,
  input  wire                               button_level_i,
  input  wire                               busy_req_i,
  input  wire                               usb_present_i,
  input  wire                               activity_i,
  // result channel
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic                              power_latch_o,
  output logic                              power_off_event_o,
  output logic                              led_red_set_o,
  output logic                              led_clear_o,
  // register write channel
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [bpo_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire  [31:0]                       cfg_data_i
);

  bpo_pkg::cfg_t    cfg_q;
  bpo_pkg::state_t  state_q, state_d;
  bpo_pkg::item_t   item_q;
  bpo_pkg::result_t res_q, res_d;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             advance;

  // Register writes are always taken; they must only arrive while the block is idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= bpo_pkg::DebounceRst;
      cfg_q.hold_off_ms <= bpo_pkg::HoldOffRst;
      cfg_q.idle_off_ms <= bpo_pkg::IdleOffRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bpo_pkg::CfgDebounce: cfg_q.debounce_ms <= cfg_data_i[15:0];
        bpo_pkg::CfgHoldOff:  cfg_q.hold_off_ms <= cfg_data_i[15:0];
        bpo_pkg::CfgIdleOff:  cfg_q.idle_off_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Move the held item into the result register when that register is free or drains.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{now_ms: now_ms_i, button_level: button_level_i, busy_req: busy_req_i,
                  usb_present: usb_present_i, activity: activity_i};
    end
  end

  bpo_core u_core (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Commit the pass: state and result update together.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign power_latch_o     = res_q.power_latch;
  assign power_off_event_o = res_q.power_off_event;
  assign led_red_set_o     = res_q.led_red_set;
  assign led_clear_o       = res_q.led_clear;

  // Power-off is sticky until reset.
  a_off_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.is_off |=> state_q.is_off)
    else $error("power-off state dropped");

  // A power-off event never reports the supply as latched.
  a_event_unlatched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && power_off_event_o |-> !power_latch_o)
    else $error("power-off event with latch high");

  // A pass taken while off reports the supply released.
  a_off_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && state_q.is_off |=> out_valid_o && !power_latch_o && !power_off_event_o)
    else $error("pass while off produced a live result");

  // A held item that cannot advance stays in the input register.
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("stalled item lost");

  // Every commit of a pass lands in the result register.
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("committed pass left no result");

endmodule

`default_nettype wire

>>> dv/button_power_off_and_idle_timer_test.sv
`default_nettype none

// Self-checking bench for the long-press power-off and idle timer.
//
// What it does:
// - Walk a short table of service passes and register writes. It covers:
//   - the extreme timestamps and thresholds;
//   - a press that starts at time zero;
//   - hold flagging and the led clear on release;
//   - usb presence holding off the idle expiry.
// - Run three random phases with their own register settings. Passes form
//   well-formed press and release runs with bounce, time jumps and noise.
// - Steer the random passes away from power-off, because power-off is
//   sticky and reset is applied only once.
// - End with a closing part of the table, which takes the release power-off
//   together with an idle expiry and then shows the block staying off.
//
// Every accepted pass is predicted here and queued. Each result transfer is
// compared field by field against the oldest queued expectation.

module button_power_off_and_idle_timer_test;

  localparam int unsigned PhaseItems   = 578;
  localparam int unsigned SettleLimit  = 300;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned DrainCycles  = 4;

  typedef enum logic {RowPass, RowWrite} row_kind_e;

  // One line of the directed table: either a service pass or a register write.
  typedef struct packed {
    row_kind_e                   kind;
    logic [bpo_pkg::CfgIdxW-1:0] reg_index;
    logic [31:0]                 reg_data;
    bpo_pkg::item_t              pass;
    logic                        hand_typed;
    bpo_pkg::result_t            want;
  } script_row_t;

  logic                        clk_i             = 1'b0;
  logic                        rst_ni            = 1'b0;
  logic                        in_valid_i        = 1'b0;
  logic                        in_ready_o;
  logic [31:0]                 now_ms_i          = '0;
  logic                        button_level_i    = 1'b0;
  logic                        busy_req_i        = 1'b0;
  logic                        usb_present_i     = 1'b0;
  logic                        activity_i        = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i       = 1'b0;
  logic                        power_latch_o;
  logic                        power_off_event_o;
  logic                        led_red_set_o;
  logic                        led_clear_o;
  logic                        cfg_valid_i       = 1'b0;
  logic                        cfg_ready_o;
  logic [bpo_pkg::CfgIdxW-1:0] cfg_index_i       = '0;
  logic [31:0]                 cfg_data_i        = '0;

  // Predictor copy of the registers and the timer state.
  bpo_pkg::cfg_t    timer_cfg;
  bpo_pkg::state_t  timer_state;
  bpo_pkg::result_t pending_passes [$];
  script_row_t      script [$];

  int unsigned send_idle_pct  = 27;
  int unsigned sink_stall_pct = 58;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Random pass generator: running timestamp and the current button run.
  logic [31:0] gen_now   = '0;
  logic        seg_level = 1'b0;
  int unsigned seg_left  = 0;

  button_power_off_and_idle_timer u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .now_ms_i          (now_ms_i),
    .button_level_i    (button_level_i),
    .busy_req_i        (busy_req_i),
    .usb_present_i     (usb_present_i),
    .activity_i        (activity_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .power_latch_o     (power_latch_o),
    .power_off_event_o (power_off_event_o),
    .led_red_set_o     (led_red_set_o),
    .led_clear_o       (led_clear_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // One service pass: activity notice, debounce with press and release,
  // hold indication, then the idle timer. All time differences wrap at 32 bits.
  function automatic bpo_pkg::result_t service_pass(input bpo_pkg::cfg_t cfg,
                                                    input bpo_pkg::state_t cur,
                                                    input bpo_pkg::item_t pass,
                                                    output bpo_pkg::state_t nxt);
    bpo_pkg::result_t res;
    logic [31:0]      age;
    logic             timed;
    logic             done;
    res  = '0;
    nxt  = cur;
    done = cur.is_off;
    if (!done) begin
      if (pass.activity) nxt.last_activity_ms = pass.now_ms;
      if (pass.button_level != nxt.last_raw_level) begin
        nxt.change_time    = pass.now_ms;
        nxt.last_raw_level = pass.button_level;
      end
      age = pass.now_ms - nxt.change_time;
      if (age >= {16'd0, cfg.debounce_ms} && pass.button_level != nxt.stable_level) begin
        nxt.stable_level = pass.button_level;
        if (pass.button_level) begin
          nxt.press_start      = pass.now_ms;
          nxt.hold_flagged     = 1'b0;
          nxt.last_activity_ms = pass.now_ms;
        end else begin
          // A press_start of zero reads as "not timed", so such a release never powers off.
          timed           = (nxt.press_start != 32'd0);
          age             = pass.now_ms - nxt.press_start;
          nxt.press_start = 32'd0;
          res.led_clear   = nxt.hold_flagged;
          if (timed && age >= {16'd0, cfg.hold_off_ms}) begin
            nxt.is_off          = 1'b1;
            res.power_off_event = 1'b1;
            done                = 1'b1;
          end
        end
      end
    end
    if (!done) begin
      age = pass.now_ms - nxt.press_start;
      if (nxt.stable_level && nxt.press_start != 32'd0 && !nxt.hold_flagged &&
          age >= {16'd0, cfg.hold_off_ms}) begin
        nxt.hold_flagged = 1'b1;
        res.led_red_set  = 1'b1;
      end
      age = pass.now_ms - nxt.last_activity_ms;
      if (pass.busy_req) begin
        nxt.last_activity_ms = pass.now_ms;
      end else if (age >= cfg.idle_off_ms) begin
        if (pass.usb_present) begin
          nxt.last_activity_ms = pass.now_ms;
        end else begin
          nxt.is_off          = 1'b1;
          res.power_off_event = 1'b1;
        end
      end
      res.power_latch = !nxt.is_off;
    end
    return res;
  endfunction

  function automatic script_row_t pass_row(input logic [31:0] stamp, input logic [3:0] levels,
                                           input logic hand_typed, input logic [3:0] want);
    script_row_t row;
    row            = '0;
    row.kind       = RowPass;
    row.pass       = {stamp, levels};
    row.hand_typed = hand_typed;
    row.want       = want;
    return row;
  endfunction

  function automatic script_row_t write_row(input logic [bpo_pkg::CfgIdxW-1:0] idx,
                                            input logic [31:0] data);
    script_row_t row;
    row           = '0;
    row.kind      = RowWrite;
    row.reg_index = idx;
    row.reg_data  = data;
    return row;
  endfunction

  // Present one pass, hold it until the transfer, then queue its expected result.
  task automatic drive_pass(input bpo_pkg::item_t pass, input logic hand_typed,
                            input bpo_pkg::result_t want);
    bpo_pkg::state_t  after;
    bpo_pkg::result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    now_ms_i       <= pass.now_ms;
    button_level_i <= pass.button_level;
    busy_req_i     <= pass.busy_req;
    usb_present_i  <= pass.usb_present;
    activity_i     <= pass.activity;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted   = service_pass(timer_cfg, timer_state, pass, after);
    timer_state = after;
    pending_passes.push_back(hand_typed ? want : predicted);
  endtask

  // Write a register only with the pipeline empty: drop valid, drain, let the
  // two-stage pipeline settle, then do the write transfer.
  task automatic write_reg(input logic [bpo_pkg::CfgIdxW-1:0] idx, input logic [31:0] data);
    in_valid_i <= 1'b0;
    while (pending_passes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      bpo_pkg::CfgDebounce: timer_cfg.debounce_ms = data[15:0];
      bpo_pkg::CfgHoldOff:  timer_cfg.hold_off_ms = data[15:0];
      bpo_pkg::CfgIdleOff:  timer_cfg.idle_off_ms = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic walk_script(input int unsigned first_row, input int unsigned end_row);
    for (int unsigned r = first_row; r < end_row; r++) begin
      if (script[r].kind == RowWrite) begin
        write_reg(script[r].reg_index, script[r].reg_data);
      end else begin
        drive_pass(script[r].pass, script[r].hand_typed, script[r].want);
      end
    end
  endtask

  // Build a random pass. Most passes form button runs with bounce and forward
  // time steps. A few are noise or step back in time. A pass that would power
  // off is steered away:
  // - mark it busy;
  // - if it is still a release power-off, move the release inside the hold time;
  // - as a last resort, hold the button down.
  task automatic make_random_pass(input logic force_release, output bpo_pkg::item_t pass);
    int unsigned      mode;
    int unsigned      span;
    bpo_pkg::item_t   trial;
    bpo_pkg::state_t  after;
    bpo_pkg::result_t res;
    mode = $urandom_range(0, 99);
    span = timer_cfg.debounce_ms + timer_cfg.hold_off_ms / 8 + 3;
    if (seg_left == 0) begin
      seg_level = ~seg_level;
      seg_left  = $urandom_range(2, 30);
    end
    seg_left--;
    if (mode >= 7) begin
      gen_now = gen_now + $urandom_range(0, span);
    end else if (mode >= 4) begin
      gen_now = gen_now - $urandom_range(0, 2 * timer_cfg.hold_off_ms + 2);
    end
    if (mode < 4) begin
      trial.now_ms       = $urandom;
      trial.button_level = 1'($urandom_range(0, 1));
    end else begin
      trial.now_ms       = gen_now;
      trial.button_level = ($urandom_range(0, 99) < 12) ? ~seg_level : seg_level;
    end
    trial.busy_req    = ($urandom_range(0, 99) < 15);
    trial.usb_present = ($urandom_range(0, 99) < 30);
    trial.activity    = ($urandom_range(0, 99) < 10);
    if (force_release) trial.button_level = 1'b0;
    res = service_pass(timer_cfg, timer_state, trial, after);
    if (res.power_off_event) begin
      trial.busy_req = 1'b1;
      res = service_pass(timer_cfg, timer_state, trial, after);
    end
    if (res.power_off_event && timer_cfg.hold_off_ms != 16'd0) begin
      trial.now_ms = timer_state.press_start + $urandom_range(0, timer_cfg.hold_off_ms - 1);
      gen_now      = trial.now_ms;
      res = service_pass(timer_cfg, timer_state, trial, after);
    end
    if (res.power_off_event) trial.button_level = 1'b1;
    pass = trial;
  endtask

  // Result side: check every transfer, then pick the stall for the next cycle.
  always @(posedge clk_i) begin : result_sink
    bpo_pkg::result_t seen;
    bpo_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen = {power_latch_o, power_off_event_o, led_red_set_o, led_clear_o};
      if (pending_passes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit) begin
          $display("%0t: result with no pass pending: latch=%b off=%b red=%b clr=%b",
                   $time, seen.power_latch, seen.power_off_event, seen.led_red_set,
                   seen.led_clear);
        end
      end else begin
        want = pending_passes.pop_front();
        if (seen.power_latch !== want.power_latch ||
            seen.power_off_event !== want.power_off_event ||
            seen.led_red_set !== want.led_red_set ||
            seen.led_clear !== want.led_clear) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit) begin
            $display("%0t: result mismatch: expected latch=%b off=%b red=%b clr=%b, %s",
                     $time, want.power_latch, want.power_off_event, want.led_red_set,
                     want.led_clear, "got below");
            $display("    got latch=%b off=%b red=%b clr=%b",
                     seen.power_latch, seen.power_off_event, seen.led_red_set,
                     seen.led_clear);
          end
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned    opening_rows;
    bpo_pkg::item_t pass;
    // Opening rows. The two passes right after reset have their result written out.
    script.push_back(pass_row(32'd0,          4'b0000, 1'b1, 4'b1000));
    // Top timestamp: idle has long expired, but usb present counts as activity.
    script.push_back(pass_row(32'hFFFF_FFFF,  4'b1010, 1'b1, 4'b1000));
    script.push_back(write_row(bpo_pkg::CfgDebounce, 32'd0));
    // Press accepted at time zero: never timed, so no red and no power-off.
    script.push_back(pass_row(32'd0,          4'b1100, 1'b0, 4'b0000));
    script.push_back(pass_row(32'd5000,       4'b1100, 1'b0, 4'b0000));
    script.push_back(pass_row(32'd5001,       4'b0101, 1'b0, 4'b0000));
    script.push_back(write_row(bpo_pkg::CfgHoldOff, 32'd10));
    script.push_back(write_row(bpo_pkg::CfgIdleOff, 32'd100));
    // Timed press: red once the hold is reached, only once.
    script.push_back(pass_row(32'd6000,       4'b1001, 1'b0, 4'b0000));
    script.push_back(pass_row(32'd6010,       4'b1000, 1'b0, 4'b0000));
    script.push_back(pass_row(32'd6011,       4'b1000, 1'b0, 4'b0000));
    // Raise hold to the top: release after red clears the LED without power-off.
    script.push_back(write_row(bpo_pkg::CfgHoldOff, 32'd65535));
    script.push_back(pass_row(32'd6012,       4'b0100, 1'b0, 4'b0000));
    // Top debounce: the level must sit unchanged for the full 65535 ms.
    script.push_back(write_row(bpo_pkg::CfgDebounce, 32'd65535));
    script.push_back(pass_row(32'd6100,       4'b1100, 1'b0, 4'b0000));
    script.push_back(pass_row(32'd71634,      4'b1100, 1'b0, 4'b0000));
    script.push_back(pass_row(32'd71635,      4'b1100, 1'b0, 4'b0000));
    script.push_back(pass_row(32'd137170,     4'b1100, 1'b0, 4'b0000));
    script.push_back(write_row(bpo_pkg::CfgIdleOff, 32'hFFFF_FFFF));
    script.push_back(pass_row(32'd137171,     4'b0000, 1'b0, 4'b0000));
    script.push_back(pass_row(32'd137172,     4'b1001, 1'b0, 4'b0000));
    opening_rows = script.size();
    // Closing rows. Zero thresholds: accept at once, flag the hold at once,
    // expire idle on every pass that is neither busy nor on usb. The release then
    // meets an idle expiry in the same pass, and afterwards the block stays off
    // while register writes still go through.
    script.push_back(write_row(bpo_pkg::CfgDebounce, 32'd0));
    script.push_back(write_row(bpo_pkg::CfgHoldOff, 32'd0));
    script.push_back(write_row(bpo_pkg::CfgIdleOff, 32'd0));
    script.push_back(pass_row(32'h8000_0000,  4'b0100, 1'b0, 4'b0000));
    script.push_back(pass_row(32'h8000_0001,  4'b1100, 1'b0, 4'b0000));
    script.push_back(pass_row(32'h8000_0002,  4'b1010, 1'b0, 4'b0000));
    script.push_back(pass_row(32'h8000_0003,  4'b0000, 1'b0, 4'b0000));
    script.push_back(pass_row(32'h8000_0004,  4'b1101, 1'b0, 4'b0000));
    script.push_back(write_row(bpo_pkg::CfgIdleOff, 32'hFFFF_FFFF));
    script.push_back(pass_row(32'hFFFF_FFFF,  4'b0000, 1'b0, 4'b0000));

    timer_cfg   = {bpo_pkg::DebounceRst, bpo_pkg::HoldOffRst, bpo_pkg::IdleOffRst};
    timer_state = '0;

    // Hold reset, then release it on an edge.
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    walk_script(0, opening_rows);

    // Random phases: the receiver stalls more in the first, the sender idles more in
    // the second, and neither side idles or stalls in the third.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 27 : (phase == 1) ? 58 : 0;
      sink_stall_pct = (phase == 0) ? 58 : (phase == 1) ? 27 : 0;
      write_reg(bpo_pkg::CfgDebounce, (phase == 1) ? 32'd0 : $urandom_range(1, 40));
      write_reg(bpo_pkg::CfgHoldOff, $urandom_range(1, 300));
      write_reg(bpo_pkg::CfgIdleOff, $urandom_range(150, 3000));
      // Start the first phase just below the wrap of the timestamp.
      gen_now = (phase == 0) ? 32'hFFFF_F000 : $urandom;
      repeat (PhaseItems) begin
        make_random_pass(1'b0, pass);
        drive_pass(pass, 1'b0, '0);
      end
    end

    // Release the button so that the closing rows start from a known level.
    for (int unsigned n = 0; n < SettleLimit && timer_state.stable_level; n++) begin
      make_random_pass(1'b1, pass);
      drive_pass(pass, 1'b0, '0);
    end

    walk_script(opening_rows, script.size());

    // Drain the remaining results, then keep the clock running to catch strays.
    in_valid_i <= 1'b0;
    while (pending_passes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
